// ===== rtl/mtbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbs_pkg
// Shared types and constants of the multi-table binary search block.
// ----------------------------------------------------------------------------
package mtbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int TABLE_COUNT         = 4;

   localparam int KEY_WIDTH        = 32;
   localparam int SEARCH_KEY_WIDTH = 16;
   localparam int INDEX_WIDTH      = 10;
   localparam int COUNT_WIDTH      = 11;
   localparam int TABLE_WIDTH      = 2;
   localparam int KIND_WIDTH       = 2;
   localparam int SUBKIND_WIDTH    = 6;
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [TABLE_WIDTH-1:0] TABLE_ZERO  = 2'd0;
   localparam logic [TABLE_WIDTH-1:0] TABLE_ONE   = 2'd1;
   localparam logic [TABLE_WIDTH-1:0] TABLE_TWO   = 2'd2;
   localparam logic [TABLE_WIDTH-1:0] TABLE_THREE = 2'd3;

   localparam logic [KIND_WIDTH-1:0]    KIND_SPLIT    = 2'd2;
   localparam logic [SUBKIND_WIDTH-1:0] SPLIT_SUBKIND = 6'h23;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_ZERO  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_ONE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_TWO   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_THREE = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO_RESET  = 11'h32b;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE_RESET   = 11'h1dc;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TWO_RESET   = 11'h0c0;
   localparam logic [COUNT_WIDTH-1:0] COUNT_THREE_RESET = 11'h0df;

   typedef struct packed {
      logic                        command;
      logic [TABLE_WIDTH-1:0]      load_table;
      logic [INDEX_WIDTH-1:0]      load_index;
      logic [KEY_WIDTH-1:0]        load_key;
      logic [SEARCH_KEY_WIDTH-1:0] search_key;
      logic [KIND_WIDTH-1:0]       kind;
      logic [SUBKIND_WIDTH-1:0]    subkind;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [TABLE_WIDTH-1:0] hit_table;
      logic [INDEX_WIDTH-1:0] hit_index;
   } rsp_type;

   typedef struct packed {
      logic load_en;
      logic lookup_start;
      logic search_en;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
   } dp_status_type;

endpackage

// ===== rtl/mtbs_ram.sv =====
// ----------------------------------------------------------------------------
// mtbs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mtbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mtbs_datapath.sv =====
// ----------------------------------------------------------------------------
// mtbs_datapath
// Count registers, key memory and the lower-bound search registers.
// ----------------------------------------------------------------------------
module mtbs_datapath #(
   parameter int TABLE_DEPTH = mtbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mtbs_pkg::req_type                        req_data,
   input  mtbs_pkg::dp_cmd_type                     cmd,
   output mtbs_pkg::dp_status_type                  status,
   input  logic                                     csr_wr_en,
   input  logic [mtbs_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [mtbs_pkg::COUNT_WIDTH-1:0]         csr_wdata,
   output mtbs_pkg::rsp_type                        rsp_data
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int SW    = (CW > mtbs_pkg::COUNT_WIDTH) ? CW : mtbs_pkg::COUNT_WIDTH;
   localparam int XW    = (CW > mtbs_pkg::INDEX_WIDTH) ? CW : mtbs_pkg::INDEX_WIDTH;
   localparam int RDEP  = mtbs_pkg::TABLE_COUNT * (1 << AW);
   localparam int RAW   = $clog2(RDEP);
   localparam int TW    = mtbs_pkg::TABLE_WIDTH;

   logic [mtbs_pkg::COUNT_WIDTH-1:0] count_zero_ff, count_one_ff;
   logic [mtbs_pkg::COUNT_WIDTH-1:0] count_two_ff, count_three_ff;

   logic [CW-1:0]                         lo_ff, lo_in;
   logic [CW-1:0]                         hi_ff, hi_in;
   logic [CW-1:0]                         cnt_ff, cnt_in;
   logic [mtbs_pkg::SEARCH_KEY_WIDTH-1:0] key_ff, key_in;
   logic [TW-1:0]                         sel_ff, sel_in;
   mtbs_pkg::rsp_type                     rsp_ff, rsp_in;

   logic [TW-1:0]                    sel_req;
   logic [mtbs_pkg::COUNT_WIDTH-1:0] count_raw;
   logic [SW-1:0]                    count_wide;
   logic [CW-1:0]                    cnt_req;
   logic [CW:0]                      sum_cur, sum_in;
   logic [CW-1:0]                    mid_cur, mid_in;
   logic                             probe_active;
   logic                             key_less;
   logic                             key_equal;
   logic                             found;
   logic [mtbs_pkg::KEY_WIDTH-1:0]   key_ext;
   logic [mtbs_pkg::KEY_WIDTH-1:0]   rd_data;
   logic [RAW-1:0]                   rd_addr;
   logic [RAW-1:0]                   wr_addr;
   logic                             wr_en;
   logic [AW-1:0]                    rd_index;
   logic                             load_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_zero_ff  <= mtbs_pkg::COUNT_ZERO_RESET;
         count_one_ff   <= mtbs_pkg::COUNT_ONE_RESET;
         count_two_ff   <= mtbs_pkg::COUNT_TWO_RESET;
         count_three_ff <= mtbs_pkg::COUNT_THREE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            mtbs_pkg::CSR_COUNT_ZERO:  count_zero_ff  <= csr_wdata;
            mtbs_pkg::CSR_COUNT_ONE:   count_one_ff   <= csr_wdata;
            mtbs_pkg::CSR_COUNT_TWO:   count_two_ff   <= csr_wdata;
            mtbs_pkg::CSR_COUNT_THREE: count_three_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_data.kind == mtbs_pkg::KIND_SPLIT &&
          req_data.subkind == mtbs_pkg::SPLIT_SUBKIND) begin
         sel_req = mtbs_pkg::TABLE_ZERO;
      end else begin
         sel_req = req_data.kind;
      end
      case (sel_req)
         mtbs_pkg::TABLE_ZERO:  count_raw = count_zero_ff;
         mtbs_pkg::TABLE_ONE:   count_raw = count_one_ff;
         mtbs_pkg::TABLE_TWO:   count_raw = count_two_ff;
         mtbs_pkg::TABLE_THREE: count_raw = count_three_ff;
         default:               count_raw = count_three_ff;
      endcase
      count_wide = SW'(count_raw);
      if (count_wide > SW'(TABLE_DEPTH)) begin
         cnt_req = CW'(TABLE_DEPTH);
      end else begin
         cnt_req = CW'(count_wide);
      end
   end

   assign sum_cur      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cur      = sum_cur[CW:1];
   assign probe_active = lo_ff < hi_ff;
   assign key_ext      = {{(mtbs_pkg::KEY_WIDTH - mtbs_pkg::SEARCH_KEY_WIDTH){1'b0}}, key_ff};
   assign key_less     = rd_data < key_ext;
   assign key_equal    = rd_data == key_ext;
   assign found        = (lo_ff < cnt_ff) && key_equal;

   assign status.search_done = !probe_active;

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      cnt_in = cnt_ff;
      key_in = key_ff;
      sel_in = sel_ff;
      if (cmd.lookup_start) begin
         lo_in  = '0;
         hi_in  = cnt_req;
         cnt_in = cnt_req;
         key_in = req_data.search_key;
         sel_in = sel_req;
      end else if (cmd.search_en && probe_active) begin
         if (key_less) begin
            lo_in = mid_cur + CW'(1);
         end else begin
            hi_in = mid_cur;
         end
      end
   end

   assign sum_in = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in = sum_in[CW:1];

   always_comb begin
      if (lo_in < hi_in) begin
         rd_index = AW'(mid_in);
      end else begin
         rd_index = AW'(lo_in);
      end
      rd_addr = {sel_in, rd_index};
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.found     = found;
         rsp_in.hit_table = sel_ff;
         if (found) begin
            rsp_in.hit_index = mtbs_pkg::INDEX_WIDTH'(XW'(lo_ff));
         end else begin
            rsp_in.hit_index = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      cnt_ff <= cnt_in;
      key_ff <= key_in;
      sel_ff <= sel_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   assign load_in_range = XW'(req_data.load_index) < XW'(TABLE_DEPTH);
   assign wr_en         = cmd.load_en && load_in_range;
   assign wr_addr       = {req_data.load_table, AW'(XW'(req_data.load_index))};

   mtbs_ram #(
      .WIDTH (mtbs_pkg::KEY_WIDTH),
      .DEPTH (RDEP)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.load_key),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/mtbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtbs_ctrl
// Controller that sequences loads and lookups through the datapath.
// ----------------------------------------------------------------------------
module mtbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    command,
   input  mtbs_pkg::dp_status_type status,
   output mtbs_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.load_en      = (state_ff == ST_IDLE) && start && (command == mtbs_pkg::CMD_LOAD);
      cmd.lookup_start = (state_ff == ST_IDLE) && start && (command == mtbs_pkg::CMD_LOOKUP);
      cmd.search_en    = (state_ff == ST_SEARCH);
      cmd.finish       = (state_ff == ST_SEARCH) && status.search_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         case (state_ff)
            ST_IDLE: begin
               if (cmd.lookup_start) begin
                  state_ff <= ST_SEARCH;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SEARCH: begin
               if (status.search_done) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/multi_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// multi_table_binary_search_top
// Lower-bound binary search over four loadable tables of sorted 32-bit keys.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. A load
// request writes one key into the key memory in that cycle and gives no
// response; another request may follow in the next cycle.
// A lookup request raises busy while the controller is in ST_SEARCH, where
// it makes the probes of the search (at most 11 for a full 1024-entry
// table) until search_done; the response strobe rsp_valid, registered from
// the finish command, is then high for one cycle. Busy falls in that same
// cycle, so the next request can be taken while the response is shown.
// Each probe needs one read of the single read port of the key memory.
// The receiver cannot stall; each response is valid for exactly one cycle.
// The count registers are written through the csr_ channel, which is always
// ready; they should be written only while the block is idle.
// Reset clears the controller and loads the reset counts; table contents
// are undefined until loaded.
// ----------------------------------------------------------------------------
module multi_table_binary_search_top #(
   parameter int TABLE_DEPTH = mtbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mtbs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output mtbs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mtbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mtbs_pkg::COUNT_WIDTH-1:0]     csr_wdata
);

   mtbs_pkg::dp_cmd_type    cmd;
   mtbs_pkg::dp_status_type status;
   logic                    csr_wr_en;

   assign csr_ready = 1'b1;
   assign csr_wr_en = csr_valid && csr_ready;

   mtbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_data.command),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mtbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
